>>> sv/qsf_pkg.sv
// ----------------------------------------------------------------------------
// qsf_pkg: shared types and helpers for the quintic segment fitter
// Sequencer states, coefficient selects and the constant-weight combination
// of the two knots that feeds each higher-order coefficient.
// ----------------------------------------------------------------------------
package qsf_pkg;

  localparam int VW   = 32;   // knot value width, Q16.16
  localparam int CW   = 64;   // coefficient width, Q32.32
  localparam int KW   = 38;   // weighted knot sums
  localparam int PW   = 160;  // interval powers up to the fifth
  localparam int MW   = 166;  // rounded dividend
  localparam int DW   = 162;  // divisor, four times the interval power

  localparam logic [CW-1:0] COEF_POS_LIM = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_NEG_LIM = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_POW   = 8'b0000_0010,
    ST_KSEL  = 8'b0000_0100,
    ST_LIN   = 8'b0000_1000,
    ST_DPREP = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_DFIN  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    SEL_C3,
    SEL_C4,
    SEL_C5
  } coef_sel_e;

  typedef enum logic [2:0] {
    SH_0,
    SH_16,
    SH_32,
    SH_64,
    SH_96
  } shift_e;

  typedef struct packed {
    logic signed [KW-1:0] ka;
    logic signed [KW-1:0] kv;
    logic signed [KW-1:0] kp;
  } lin_t;

  // weights on acceleration, velocity and position for one coefficient
  function automatic lin_t lin_coefs(coef_sel_e sel,
                                     logic signed [VW-1:0] a1, logic signed [VW-1:0] a2,
                                     logic signed [VW-1:0] v1, logic signed [VW-1:0] v2,
                                     logic signed [VW-1:0] p1, logic signed [VW-1:0] p2);
    lin_t r;
    logic signed [KW-1:0] ea1, ea2, ev1, ev2, dp;
    ea1 = KW'(a1);
    ea2 = KW'(a2);
    ev1 = KW'(v1);
    ev2 = KW'(v2);
    dp  = KW'(p1) - KW'(p2);
    case (sel)
      SEL_C3: begin
        r.ka = 38'sd3 * ea1 - ea2;
        r.kv = 38'sd8 * ev2 + 38'sd12 * ev1;
        r.kp = 38'sd20 * dp;
      end
      SEL_C4: begin
        r.ka = 38'sd3 * ea1 - 38'sd2 * ea2;
        r.kv = 38'sd14 * ev2 + 38'sd16 * ev1;
        r.kp = 38'sd30 * dp;
      end
      default: begin
        r.ka = ea1 - ea2;
        r.kv = 38'sd6 * ev2 + 38'sd6 * ev1;
        r.kp = 38'sd12 * dp;
      end
    endcase
    return r;
  endfunction

endpackage

>>> sv/quintic_segment_fitter.sv
// Operation: a segment-producing knot keeps the block busy, stalling the input,
//   until its result is registered at the output; no new knot is taken meanwhile.
// The work runs on the shared 38x33 multiplier and the one-bit-per-cycle restoring
//   divider (64 steps per coefficient); a knot that produces nothing is taken
//   without leaving the idle state.
// Reset: asynchronous, active low; clears the stored knot flag, min_interval to 1.
// ----------------------------------------------------------------------------
// quintic_segment_fitter
// Fits a quintic segment between consecutive trajectory knots using one shared
// multiplier and one shared divider under a small sequencer.
// ----------------------------------------------------------------------------
module quintic_segment_fitter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         start_of_set_i,
  input  logic [31:0]  knot_time_i,
  input  logic signed [31:0] knot_position_i,
  input  logic signed [31:0] knot_velocity_i,
  input  logic signed [31:0] knot_acceleration_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic signed [63:0] coef_c0_o,
  output logic signed [63:0] coef_c1_o,
  output logic signed [63:0] coef_c2_o,
  output logic signed [63:0] coef_c3_o,
  output logic signed [63:0] coef_c4_o,
  output logic signed [63:0] coef_c5_o,
  output logic [31:0]  segment_begin_o,
  output logic [31:0]  segment_end_o,
  output logic         coef_overflow_o
);

  qsf_pkg::state_e      state_q, state_d;
  qsf_pkg::coef_sel_e   cs_q, cs_d;
  logic [15:0]          min_q;
  logic                 pvalid_q, pvalid_d;
  logic [31:0]          ptime_q, ptime_d;
  logic signed [31:0]   ppos_q, ppos_d, pvel_q, pvel_d, pacc_q, pacc_d;
  logic signed [31:0]   p1_q, p1_d, v1_q, v1_d, a1_q, a1_d;
  logic [31:0]          tbeg_q, tbeg_d, t_q, t_d;
  logic [63:0]          t2_q, t2_d;
  logic [qsf_pkg::PW-1:0] pow_q, pow_d;
  logic signed [qsf_pkg::PW-1:0] acc_q, acc_d;
  logic [1:0]           j_q, j_d, pd_q, pd_d;
  logic signed [37:0]   ka_q, ka_d, kv_q, kv_d, kp_q, kp_d;
  logic                 neg_q, neg_d, bigq_q, bigq_d;
  logic [qsf_pkg::DW-1:0] rem_q, rem_d, d2_q, d2_d;
  logic [63:0]          qm_q, qm_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [63:0]          c3_q, c3_d, c4_q, c4_d, c5_q, c5_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [63:0]          oc0_q, oc0_d, oc1_q, oc1_d, oc2_q, oc2_d;
  logic [63:0]          oc3_q, oc3_d, oc4_q, oc4_d, oc5_q, oc5_d;
  logic [31:0]          obeg_q, obeg_d, oend_q, oend_d;
  logic                 oovf_q, oovf_d;

  // shared multiplier and accumulator
  logic signed [37:0]   mul_a;
  logic signed [32:0]   mul_b;
  qsf_pkg::shift_e      sh;
  logic signed [70:0]   prod;
  logic signed [qsf_pkg::PW-1:0] prod_ext, prod_sh, acc_sum;
  logic [31:0]          pow_word;

  // divider setup and step
  logic                 xneg;
  logic [qsf_pkg::PW-1:0] xabs;
  logic [98:0]          xmag;
  logic [qsf_pkg::MW-1:0] msh, mval;
  logic [qsf_pkg::DW-1:0] rem_init, d2_new;
  logic [qsf_pkg::DW:0] trial;
  logic [63:0]          lim, qmag;
  logic                 sat;
  qsf_pkg::lin_t        lc;

  logic                 in_take, out_take, keep, emit;
  logic [31:0]          tdiff;

  assign in_stall_o = (state_q != qsf_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign keep       = pvalid_q && !start_of_set_i;
  assign tdiff      = knot_time_i - ptime_q;
  assign emit       = keep && (knot_time_i > ptime_q) && (tdiff > {16'b0, min_q});

  assign pow_word = pow_q[{j_q, 5'd0} +: 32];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sh    = qsf_pkg::SH_0;
    case (state_q)
      qsf_pkg::ST_POW: begin
        mul_a = {6'b0, t_q};
        mul_b = {1'b0, pow_word};
        case (j_q)
          2'd0:    sh = qsf_pkg::SH_0;
          2'd1:    sh = qsf_pkg::SH_32;
          2'd2:    sh = qsf_pkg::SH_64;
          default: sh = qsf_pkg::SH_96;
        endcase
      end
      qsf_pkg::ST_LIN: begin
        case (j_q)
          2'd0: begin
            mul_a = ka_q;
            mul_b = {1'b0, t2_q[31:0]};
            sh    = qsf_pkg::SH_0;
          end
          2'd1: begin
            mul_a = ka_q;
            mul_b = {1'b0, t2_q[63:32]};
            sh    = qsf_pkg::SH_32;
          end
          2'd2: begin
            mul_a = kv_q;
            mul_b = {1'b0, t_q};
            sh    = qsf_pkg::SH_16;
          end
          default: begin
            mul_a = kp_q;
            mul_b = 33'sd1;
            sh    = qsf_pkg::SH_32;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(qsf_pkg::PW-71){prod[70]}}, prod};

  always_comb begin
    case (sh)
      qsf_pkg::SH_0:  prod_sh = prod_ext;
      qsf_pkg::SH_16: prod_sh = prod_ext <<< 16;
      qsf_pkg::SH_32: prod_sh = prod_ext <<< 32;
      qsf_pkg::SH_64: prod_sh = prod_ext <<< 64;
      qsf_pkg::SH_96: prod_sh = prod_ext <<< 96;
      default:        prod_sh = prod_ext;
    endcase
  end

  assign acc_sum = acc_q + prod_sh;

  // rounded dividend 2|num| + den, divisor 2*den
  assign xneg = acc_q[qsf_pkg::PW-1];
  assign xabs = xneg ? qsf_pkg::PW'(-acc_q) : qsf_pkg::PW'(acc_q);
  assign xmag = xabs[98:0];

  always_comb begin
    case (cs_q)
      qsf_pkg::SEL_C3: msh = {34'b0, xmag, 33'b0};
      qsf_pkg::SEL_C4: msh = {18'b0, xmag, 49'b0};
      default:         msh = {2'b0, xmag, 65'b0};
    endcase
  end

  assign mval     = msh + {5'b0, pow_q, 1'b0};
  assign rem_init = {60'b0, mval[qsf_pkg::MW-1:64]};
  assign d2_new   = {pow_q, 2'b0};
  assign trial    = {rem_q, qm_q[63]} - {1'b0, d2_q};

  assign lim  = neg_q ? qsf_pkg::COEF_NEG_LIM : qsf_pkg::COEF_POS_LIM;
  assign sat  = bigq_q || (qm_q > lim);
  assign qmag = sat ? lim : qm_q;

  assign lc = qsf_pkg::lin_coefs(cs_q, a1_q, pacc_q, v1_q, pvel_q, p1_q, ppos_q);

  always_comb begin
    state_d     = state_q;
    cs_d        = cs_q;
    pvalid_d    = pvalid_q;
    ptime_d     = ptime_q;
    ppos_d      = ppos_q;
    pvel_d      = pvel_q;
    pacc_d      = pacc_q;
    p1_d        = p1_q;
    v1_d        = v1_q;
    a1_d        = a1_q;
    tbeg_d      = tbeg_q;
    t_d         = t_q;
    t2_d        = t2_q;
    pow_d       = pow_q;
    acc_d       = acc_q;
    j_d         = j_q;
    pd_d        = pd_q;
    ka_d        = ka_q;
    kv_d        = kv_q;
    kp_d        = kp_q;
    neg_d       = neg_q;
    bigq_d      = bigq_q;
    rem_d       = rem_q;
    d2_d        = d2_q;
    qm_d        = qm_q;
    cnt_d       = cnt_q;
    c3_d        = c3_q;
    c4_d        = c4_q;
    c5_d        = c5_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_take;
    oc0_d       = oc0_q;
    oc1_d       = oc1_q;
    oc2_d       = oc2_q;
    oc3_d       = oc3_q;
    oc4_d       = oc4_q;
    oc5_d       = oc5_q;
    obeg_d      = obeg_q;
    oend_d      = oend_q;
    oovf_d      = oovf_q;

    case (state_q)
      qsf_pkg::ST_IDLE: begin
        if (in_take) begin
          pvalid_d = 1'b1;
          ptime_d  = knot_time_i;
          ppos_d   = knot_position_i;
          pvel_d   = knot_velocity_i;
          pacc_d   = knot_acceleration_i;
          if (emit) begin
            p1_d    = ppos_q;
            v1_d    = pvel_q;
            a1_d    = pacc_q;
            tbeg_d  = ptime_q;
            t_d     = tdiff;
            pow_d   = {128'b0, tdiff};
            acc_d   = '0;
            j_d     = 2'd0;
            pd_d    = 2'd0;
            cs_d    = qsf_pkg::SEL_C3;
            ovf_d   = 1'b0;
            state_d = qsf_pkg::ST_POW;
          end
        end
      end
      qsf_pkg::ST_POW: begin
        // multiply the running power by the interval, one word per cycle
        acc_d = acc_sum;
        j_d   = j_q + 2'd1;
        if (j_q == pd_q) begin
          pow_d = acc_sum;
          acc_d = '0;
          j_d   = 2'd0;
          pd_d  = pd_q + 2'd1;
          if (pd_q == 2'd0) begin
            t2_d = acc_sum[63:0];
          end else begin
            state_d = qsf_pkg::ST_KSEL;
          end
        end
      end
      qsf_pkg::ST_KSEL: begin
        ka_d    = lc.ka;
        kv_d    = lc.kv;
        kp_d    = lc.kp;
        acc_d   = '0;
        j_d     = 2'd0;
        state_d = qsf_pkg::ST_LIN;
      end
      qsf_pkg::ST_LIN: begin
        acc_d = acc_sum;
        j_d   = j_q + 2'd1;
        if (j_q == 2'd3) begin
          state_d = qsf_pkg::ST_DPREP;
        end
      end
      qsf_pkg::ST_DPREP: begin
        neg_d   = (cs_q == qsf_pkg::SEL_C4) ? xneg : (!xneg && (acc_q != '0));
        bigq_d  = (rem_init >= d2_new);
        // quotient saturates anyway; clear the remainder to keep it in range
        rem_d   = (rem_init >= d2_new) ? '0 : rem_init;
        d2_d    = d2_new;
        qm_d    = mval[63:0];
        cnt_d   = '0;
        state_d = qsf_pkg::ST_DIV;
      end
      qsf_pkg::ST_DIV: begin
        if (!trial[qsf_pkg::DW]) begin
          rem_d = trial[qsf_pkg::DW-1:0];
        end else begin
          rem_d = {rem_q[qsf_pkg::DW-2:0], qm_q[63]};
        end
        qm_d  = {qm_q[62:0], !trial[qsf_pkg::DW]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = qsf_pkg::ST_DFIN;
        end
      end
      qsf_pkg::ST_DFIN: begin
        ovf_d = ovf_q || sat;
        acc_d = '0;
        case (cs_q)
          qsf_pkg::SEL_C3: begin
            c3_d    = neg_q ? (64'd0 - qmag) : qmag;
            cs_d    = qsf_pkg::SEL_C4;
            state_d = qsf_pkg::ST_POW;
          end
          qsf_pkg::SEL_C4: begin
            c4_d    = neg_q ? (64'd0 - qmag) : qmag;
            cs_d    = qsf_pkg::SEL_C5;
            state_d = qsf_pkg::ST_POW;
          end
          default: begin
            c5_d    = neg_q ? (64'd0 - qmag) : qmag;
            state_d = qsf_pkg::ST_OUT;
          end
        endcase
      end
      qsf_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          oc0_d       = {{16{p1_q[31]}}, p1_q, 16'b0};
          oc1_d       = {{16{v1_q[31]}}, v1_q, 16'b0};
          oc2_d       = {{17{a1_q[31]}}, a1_q, 15'b0};
          oc3_d       = c3_q;
          oc4_d       = c4_q;
          oc5_d       = c5_q;
          obeg_d      = tbeg_q;
          oend_d      = ptime_q;
          oovf_d      = ovf_q;
          state_d     = qsf_pkg::ST_IDLE;
        end
      end
      default: state_d = qsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qsf_pkg::ST_IDLE;
      cs_q        <= qsf_pkg::SEL_C3;
      min_q       <= 16'd1;
      pvalid_q    <= 1'b0;
      j_q         <= 2'd0;
      pd_q        <= 2'd0;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cs_q        <= cs_d;
      if (cfg_we_i) begin
        min_q <= cfg_data_i;
      end
      pvalid_q    <= pvalid_d;
      j_q         <= j_d;
      pd_q        <= pd_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptime_q <= ptime_d;
    ppos_q  <= ppos_d;
    pvel_q  <= pvel_d;
    pacc_q  <= pacc_d;
    p1_q    <= p1_d;
    v1_q    <= v1_d;
    a1_q    <= a1_d;
    tbeg_q  <= tbeg_d;
    t_q     <= t_d;
    t2_q    <= t2_d;
    pow_q   <= pow_d;
    acc_q   <= acc_d;
    ka_q    <= ka_d;
    kv_q    <= kv_d;
    kp_q    <= kp_d;
    neg_q   <= neg_d;
    bigq_q  <= bigq_d;
    rem_q   <= rem_d;
    d2_q    <= d2_d;
    qm_q    <= qm_d;
    c3_q    <= c3_d;
    c4_q    <= c4_d;
    c5_q    <= c5_d;
    ovf_q   <= ovf_d;
    oc0_q   <= oc0_d;
    oc1_q   <= oc1_d;
    oc2_q   <= oc2_d;
    oc3_q   <= oc3_d;
    oc4_q   <= oc4_d;
    oc5_q   <= oc5_d;
    obeg_q  <= obeg_d;
    oend_q  <= oend_d;
    oovf_q  <= oovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign coef_c0_o       = oc0_q;
  assign coef_c1_o       = oc1_q;
  assign coef_c2_o       = oc2_q;
  assign coef_c3_o       = oc3_q;
  assign coef_c4_o       = oc4_q;
  assign coef_c5_o       = oc5_q;
  assign segment_begin_o = obeg_q;
  assign segment_end_o   = oend_q;
  assign coef_overflow_o = oovf_q;

  a_div_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qsf_pkg::ST_DIV) |-> (rem_q < d2_q))
    else $error("divider remainder not below divisor");

  a_square_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qsf_pkg::ST_KSEL) |-> (t2_q == 64'(t_q) * 64'(t_q)))
    else $error("interval square wrong");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == qsf_pkg::ST_OUT))
    else $error("result raised outside the output step");

  a_interval_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qsf_pkg::ST_POW) |-> (t_q > {16'b0, min_q}))
    else $error("segment started on a short interval");

endmodule

>>> bench/quintic_segment_fitter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quintic_segment_fitter_test: self-checking bench for the segment fitter
// Streams directed and random knot sets through the block, predicts every
// segment with exact wide arithmetic and checks the coefficients, end times
// and overflow flag under random idling on both sides.
// ----------------------------------------------------------------------------
module quintic_segment_fitter_test;

  localparam int CYCLE_LIMIT = 3000000;

  typedef logic signed [319:0] wide_t;

  typedef struct {
    logic [63:0] c[6];
    logic [31:0] seg_begin;
    logic [31:0] seg_end;
    logic        ovf;
  } segment_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        start_of_set_i;
  logic [31:0] knot_time_i;
  logic signed [31:0] knot_position_i;
  logic signed [31:0] knot_velocity_i;
  logic signed [31:0] knot_acceleration_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [63:0] coef_c0_o, coef_c1_o, coef_c2_o;
  logic signed [63:0] coef_c3_o, coef_c4_o, coef_c5_o;
  logic [31:0] segment_begin_o;
  logic [31:0] segment_end_o;
  logic        coef_overflow_o;

  quintic_segment_fitter i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .start_of_set_i      (start_of_set_i),
    .knot_time_i         (knot_time_i),
    .knot_position_i     (knot_position_i),
    .knot_velocity_i     (knot_velocity_i),
    .knot_acceleration_i (knot_acceleration_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .coef_c0_o           (coef_c0_o),
    .coef_c1_o           (coef_c1_o),
    .coef_c2_o           (coef_c2_o),
    .coef_c3_o           (coef_c3_o),
    .coef_c4_o           (coef_c4_o),
    .coef_c5_o           (coef_c5_o),
    .segment_begin_o     (segment_begin_o),
    .segment_end_o       (segment_end_o),
    .coef_overflow_o     (coef_overflow_o)
  );

  // predictor copy of the block state
  logic [15:0]        min_gap;
  bit                 have_knot;
  logic [31:0]        knot_t_q;
  logic signed [31:0] knot_p_q, knot_v_q, knot_a_q;

  segment_t    pending_segments[$];
  int          errors;
  int          knots_sent;
  int          segments_seen;
  int          overflows_seen;
  int          cycles;
  int          rx_hold;
  bit          quiet;
  logic [31:0] last_time;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding", cycles,
               pending_segments.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t: mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // round num/den to nearest, ties away from zero, then clamp to 64 bits
  function automatic logic [63:0] round_sat(wide_t num, wide_t den, inout logic ovf);
    wide_t mag, q, lim;
    bit    neg;
    neg = num[319];
    mag = neg ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    lim = neg ? (wide_t'(1) <<< 63) : ((wide_t'(1) <<< 63) - 1);
    if (q > lim) begin
      ovf = 1'b1;
      q   = lim;
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  function automatic wide_t weigh_knots(wide_t ka, wide_t kv, wide_t kp, wide_t t);
    return ka * t * t + ((kv * t) <<< 16) + (kp <<< 32);
  endfunction

  // advance the predicted state with one accepted knot
  task automatic fit_knot(bit sos, logic [31:0] tm, logic signed [31:0] p2,
                          logic signed [31:0] v2, logic signed [31:0] a2);
    segment_t s;
    wide_t    t, p1, v1, a1, x;
    if (sos) have_knot = 1'b0;
    if (have_knot && tm > knot_t_q && (tm - knot_t_q) > {16'd0, min_gap}) begin
      t  = wide_t'(tm - knot_t_q);
      p1 = wide_t'(knot_p_q);
      v1 = wide_t'(knot_v_q);
      a1 = wide_t'(knot_a_q);
      s.ovf  = 1'b0;
      s.c[0] = round_sat(p1 <<< 32, wide_t'(1) <<< 16, s.ovf);
      s.c[1] = round_sat(v1 <<< 32, wide_t'(1) <<< 16, s.ovf);
      s.c[2] = round_sat(a1 <<< 32, wide_t'(1) <<< 17, s.ovf);
      x = weigh_knots(3 * a1 - wide_t'(a2), 8 * wide_t'(v2) + 12 * v1,
                      20 * (p1 - wide_t'(p2)), t);
      s.c[3] = round_sat(-(x <<< 32), 2 * t * t * t, s.ovf);
      x = weigh_knots(3 * a1 - 2 * wide_t'(a2), 14 * wide_t'(v2) + 16 * v1,
                      30 * (p1 - wide_t'(p2)), t);
      s.c[4] = round_sat(x <<< 48, 2 * t * t * t * t, s.ovf);
      x = weigh_knots(a1 - wide_t'(a2), 6 * wide_t'(v2) + 6 * v1,
                      12 * (p1 - wide_t'(p2)), t);
      s.c[5] = round_sat(-(x <<< 64), 2 * t * t * t * t * t, s.ovf);
      s.seg_begin = knot_t_q;
      s.seg_end   = tm;
      pending_segments.insert(pending_segments.size(), s);
    end
    have_knot = 1'b1;
    knot_t_q  = tm;
    knot_p_q  = p2;
    knot_v_q  = v2;
    knot_a_q  = a2;
  endtask

  // call at a falling edge; returns at a falling edge after acceptance, at times after a random idle
  task automatic send_knot(bit sos, logic [31:0] tm, logic signed [31:0] p,
                           logic signed [31:0] v, logic signed [31:0] a);
    start_of_set_i      = sos;
    knot_time_i         = tm;
    knot_position_i     = p;
    knot_velocity_i     = v;
    knot_acceleration_i = a;
    in_valid_i          = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    fit_knot(sos, tm, p, v, a);
    knots_sent++;
    last_time = tm;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
  endtask

  task automatic drain_segments();
    in_valid_i = 1'b0;
    while (pending_segments.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_min_gap(logic [15:0] value);
    drain_segments();
    cfg_we_i   = 1'b1;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    min_gap    = value;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed(8'($urandom())));
      3: return 32'($signed(20'($urandom())));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 9))
      0: return $urandom_range(1, 4);
      1: return {16'd0, min_gap} + $urandom_range(0, 2);
      2: return $urandom_range(1, 24'hff_ffff);
      3: return $urandom();
      default: return 32'h1_0000 * $urandom_range(1, 8) + $urandom_range(0, 255);
    endcase
  endfunction

  task automatic test_directed();
    send_knot(1'b1, 32'h0000_0000, 32'h0, 32'h0, 32'h0);
    send_knot(1'b0, 32'h0000_0000, 32'h1_0000, 32'h0, 32'h0);   // zero interval
    send_knot(1'b0, 32'h0000_0001, 32'h2_0000, 32'h0, 32'h0);   // short interval
    send_knot(1'b0, 32'h0001_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_knot(1'b0, 32'h0001_0003, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_knot(1'b0, 32'h0000_1000, 32'h1234_5678, 32'h0, 32'h0); // backward
    send_knot(1'b0, 32'h0003_1000, 32'hffff_0000, 32'h0001_0000, 32'hfffe_0000);
    send_knot(1'b1, 32'hffff_0000, 32'h0, 32'h0, 32'h0);          // new set
    send_knot(1'b0, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_knot(1'b0, 32'h0000_0005, 32'h0, 32'h0, 32'h0);
    send_knot(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    write_min_gap(16'd0);
    send_knot(1'b1, 32'h10, 32'h100, 32'h0, 32'h0);
    send_knot(1'b0, 32'h11, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_knot(1'b0, 32'h12, 32'h0, 32'h0, 32'h0);
    write_min_gap(16'hffff);
    send_knot(1'b1, 32'h0, 32'h1_0000, 32'h2_0000, 32'h3_0000);
    send_knot(1'b0, 32'hffff, 32'h0, 32'h0, 32'h0);               // equal, dropped
    send_knot(1'b0, 32'h2_fffe, 32'h5_0000, 32'hfffb_0000, 32'h0);
    send_knot(1'b0, 32'h3_fffe, 32'h0, 32'h0, 32'h0);             // one above
  endtask

  task automatic test_random(int n_knots, logic [15:0] gap);
    int     left, run;
    write_min_gap(gap);
    left = n_knots;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_knot(1'($urandom_range(0, 1)), $urandom(), rand_value(), rand_value(),
                  rand_value());
        left--;
      end else begin
        run = $urandom_range(2, 12);
        send_knot(1'b1, $urandom_range(0, 32'h4000_0000), rand_value(), rand_value(),
                  rand_value());
        left--;
        repeat (run - 1) begin
          if ($urandom_range(0, 19) == 0)
            send_knot(1'b0, last_time - $urandom_range(0, 100), rand_value(), rand_value(),
                      rand_value());
          else
            send_knot(1'b0, last_time + rand_step(), rand_value(), rand_value(),
                      rand_value());
          left--;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 3000;
    send_knot(1'b1, 32'h0, rand_value(), rand_value(), rand_value());
    repeat (20) send_knot(1'b0, last_time + 32'h2_0000, rand_value(), rand_value(),
                          rand_value());
    drain_segments();
  endtask

  // output side: random stall bursts, long hold-off on request
  initial begin
    int burst;
    out_stall_i = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_stall_i = 1'b1;
        rx_hold--;
      end else if (burst > 0) begin
        out_stall_i = 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i = 1'b1;
        burst = $urandom_range(0, 12);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // check each accepted segment against the oldest prediction
  always @(posedge clk_i) begin
    segment_t s;
    logic [63:0] got[6];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      segments_seen++;
      if (pending_segments.size() == 0) begin
        errors++;
        $display("%0t: segment with no knot pair pending", $realtime);
      end else begin
        s = pending_segments.pop_front();
        got = '{coef_c0_o, coef_c1_o, coef_c2_o, coef_c3_o, coef_c4_o, coef_c5_o};
        if (s.ovf) overflows_seen++;
        for (int i = 0; i < 6; i++)
          if (got[i] !== s.c[i]) report($sformatf("coef_c%0d", i), got[i], s.c[i]);
        if (segment_begin_o !== s.seg_begin)
          report("segment_begin", 64'(segment_begin_o), 64'(s.seg_begin));
        if (segment_end_o !== s.seg_end)
          report("segment_end", 64'(segment_end_o), 64'(s.seg_end));
        if (coef_overflow_o !== s.ovf)
          report("coef_overflow", 64'(coef_overflow_o), 64'(s.ovf));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    start_of_set_i = 1'b0;
    knot_time_i = '0;
    knot_position_i = '0;
    knot_velocity_i = '0;
    knot_acceleration_i = '0;
    min_gap = 16'd1;
    have_knot = 1'b0;
    errors = 0;
    knots_sent = 0;
    segments_seen = 0;
    overflows_seen = 0;
    cycles = 0;
    rx_hold = 0;
    quiet = 1'b0;
    last_time = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(200, 16'd1);
    test_backpressure();
    test_random(200, 16'd0);
    test_random(200, 16'(($urandom_range(0, 65535))));
    test_random(150, 16'hffff);
    quiet = 1'b1;
    test_random(100, 16'd2);
    drain_segments();
    repeat (240) @(negedge clk_i);

    if (pending_segments.size() != 0) begin
      errors++;
      $display("%0d predicted segments never arrived", pending_segments.size());
    end
    $display("%0d knots sent, %0d segments checked, %0d of them saturated", knots_sent,
             segments_seen, overflows_seen);
    $display("covered gap settings 0, 1, 2, random and 65535 with long output hold-off");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
